>>> sv/sfr_pkg.sv
// Shared types, constants and per-byte functions for the stuffed frame receiver.
// Used by sfr_deframer, sfr_result_buf and stuffed_frame_receiver_crc16_core.
package sfr_pkg;

   // frame length limits
   localparam int MAX_FRAME_DEF = 64;
   localparam int MAX_DATA_DEF  = 64;

   // line codes
   localparam logic [7:0] ESC_BYTE = 8'hFE;
   localparam logic [7:0] ESC_LIT  = 8'hF0;
   localparam logic [7:0] ESC_END  = 8'h0D;

   // crc constants
   localparam logic [15:0] CRC_SEED = 16'h147A;
   localparam logic [15:0] CRC_XOR  = 16'hFFFF;

   // result kinds
   localparam logic [1:0] KIND_CMD  = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   // frame end status codes
   localparam logic [1:0] STAT_OK  = 2'd0;
   localparam logic [1:0] STAT_CRC = 2'd1;
   localparam logic [1:0] STAT_LEN = 2'd2;

   // per-frame working state
   typedef struct packed {
      logic [6:0]  raw_count;
      logic        overflow;
      logic [15:0] crc;
      logic [7:0]  d0;
      logic [7:0]  d1;
      logic [1:0]  fill;
      logic [6:0]  emitted;
   } frame_state_type;

   // one result word
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic [1:0] status;
      logic [6:0] data_count;
      logic       last;
   } result_type;

   // up to two results caused by one input byte
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } result_pair_type;

   // outcome of pushing one raw byte
   typedef struct packed {
      frame_state_type st;
      logic            hit;
      result_type      res;
   } take_type;

   function automatic frame_state_type open_frame_state();
      frame_state_type s;
      s.raw_count = '0;
      s.overflow  = 1'b0;
      s.crc       = CRC_SEED;
      s.d0        = '0;
      s.d1        = '0;
      s.fill      = '0;
      s.emitted   = '0;
      return s;
   endfunction

   // rotate left, invert, then add high byte and the new byte
   function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = {crc[14:0], crc[15]} ^ CRC_XOR;
      c = c + {8'd0, c[15:8]} + {8'd0, b};
      return c;
   endfunction

   // one raw byte through the two-byte delay and the crc
   function automatic take_type take_raw(frame_state_type st, logic [7:0] b,
                                         logic [6:0] max_frame,
                                         logic [6:0] max_data);
      take_type t;
      t.st  = st;
      t.hit = 1'b0;
      t.res = '0;
      if (!st.overflow) begin
         if (st.raw_count >= max_frame) begin
            t.st.overflow = 1'b1;
         end else begin
            if (st.fill[1]) begin
               t.st.crc = crc_step(st.crc, st.d0);
               if (st.raw_count == 7'd2) begin
                  t.hit       = 1'b1;
                  t.res.kind  = KIND_CMD;
                  t.res.value = st.d0;
               end else if (st.emitted < max_data) begin
                  t.hit        = 1'b1;
                  t.res.kind   = KIND_DATA;
                  t.res.value  = st.d0;
                  t.st.emitted = st.emitted + 7'd1;
               end
               t.st.d0 = st.d1;
               t.st.d1 = b;
            end else begin
               if (st.fill[0]) begin
                  t.st.d1 = b;
               end else begin
                  t.st.d0 = b;
               end
               t.st.fill = st.fill + 2'd1;
            end
            t.st.raw_count = st.raw_count + 7'd1;
         end
      end
      return t;
   endfunction

endpackage

>>> sv/sfr_deframer.sv
// Frame state and per-byte unstuffing, crc and result generation.
// Depends on sfr_pkg for state types and the take_raw / crc_step functions.
module sfr_deframer
   import sfr_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEF,
   parameter int MAX_DATA  = MAX_DATA_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      rx_byte,
   output result_pair_type results
);

   logic            in_frame_ff, in_frame_in;
   logic            saw_ff, saw_in;
   frame_state_type st_ff, st_in;

   logic            use_a, use_b, is_close;
   logic [7:0]      byte_a;
   take_type        ta, tb;
   logic            hit_a, hit_b;
   result_type      end_res;

   // raw byte pushes for this input byte
   always_comb begin
      byte_a = saw_ff ? ESC_BYTE : rx_byte;
      ta = take_raw(st_ff, byte_a, 7'(MAX_FRAME), 7'(MAX_DATA));
      tb = take_raw(ta.st, rx_byte, 7'(MAX_FRAME), 7'(MAX_DATA));
   end

   // frame end report
   always_comb begin
      end_res            = '0;
      end_res.kind       = KIND_END;
      end_res.data_count = st_ff.emitted;
      end_res.last       = 1'b1;
      if (st_ff.overflow || st_ff.raw_count < 7'd3) begin
         end_res.status = STAT_LEN;
      end else if ({st_ff.d0, st_ff.d1} == st_ff.crc) begin
         end_res.status = STAT_OK;
      end else begin
         end_res.status = STAT_CRC;
      end
   end

   // escape decoding and next state
   always_comb begin
      use_a       = 1'b0;
      use_b       = 1'b0;
      is_close    = 1'b0;
      in_frame_in = in_frame_ff;
      saw_in      = saw_ff;
      if (!in_frame_ff) begin
         if (saw_ff && rx_byte == ESC_BYTE) begin
            in_frame_in = 1'b1;
            saw_in      = 1'b0;
         end else begin
            saw_in = (rx_byte == ESC_BYTE);
         end
      end else if (saw_ff) begin
         saw_in = 1'b0;
         if (rx_byte == ESC_END) begin
            is_close    = 1'b1;
            in_frame_in = 1'b0;
         end else if (rx_byte == ESC_LIT) begin
            use_a = 1'b1;
         end else if (rx_byte == ESC_BYTE) begin
            use_a  = 1'b1;
            saw_in = 1'b1;
         end else begin
            use_a = 1'b1;
            use_b = 1'b1;
         end
      end else if (rx_byte == ESC_BYTE) begin
         saw_in = 1'b1;
      end else begin
         use_a = 1'b1;
      end

      if (!in_frame_ff && in_frame_in) begin
         st_in = open_frame_state();
      end else if (use_b) begin
         st_in = tb.st;
      end else if (use_a) begin
         st_in = ta.st;
      end else begin
         st_in = st_ff;
      end
   end

   // pack up to two results, last on the final one
   always_comb begin
      hit_a   = use_a && ta.hit;
      hit_b   = use_b && tb.hit;
      results = '0;
      if (is_close) begin
         results.count = 2'd1;
         results.r0    = end_res;
      end else if (hit_a) begin
         results.r0 = ta.res;
         if (hit_b) begin
            results.count   = 2'd2;
            results.r1      = tb.res;
            results.r1.last = 1'b1;
         end else begin
            results.count   = 2'd1;
            results.r0.last = 1'b1;
         end
      end else if (hit_b) begin
         results.count   = 2'd1;
         results.r0      = tb.res;
         results.r0.last = 1'b1;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         saw_ff      <= 1'b0;
         st_ff       <= open_frame_state();
      end else if (step) begin
         in_frame_ff <= in_frame_in;
         saw_ff      <= saw_in;
         st_ff       <= st_in;
      end
   end

   // raw count never passes the frame limit
   assert property (@(posedge clock) disable iff (reset)
      st_ff.raw_count <= 7'(MAX_FRAME))
      else $error("raw count beyond frame limit");

   // data words emitted never pass the data limit
   assert property (@(posedge clock) disable iff (reset)
      st_ff.emitted <= 7'(MAX_DATA))
      else $error("emitted data beyond limit");

   // nothing comes out while hunting for a start pair
   assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> results.count == 2'd0)
      else $error("result produced while hunting");

   // delay line fill stays within two bytes
   assert property (@(posedge clock) disable iff (reset)
      st_ff.fill != 2'd3)
      else $error("delay fill out of range");

endmodule

>>> sv/sfr_result_buf.sv
// Output register holding the results of one input byte, sent one word a cycle while rsp_ready is high.
// Depends on sfr_pkg for the result types.
module sfr_result_buf
   import sfr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  result_pair_type pair,
   output logic            free,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output result_type      rsp_word
);

   result_pair_type pair_ff;
   logic            idx_ff;
   logic            fire, drain_last;

   // current word and drain detection
   always_comb begin
      rsp_valid  = (pair_ff.count != 2'd0);
      rsp_word   = idx_ff ? pair_ff.r1 : pair_ff.r0;
      fire       = rsp_valid && rsp_ready;
      drain_last = fire && (idx_ff || pair_ff.count == 2'd1);
      free       = !rsp_valid || drain_last;
   end

   // hold register and word index
   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff.count <= 2'd0;
         idx_ff        <= 1'b0;
      end else if (load) begin
         pair_ff.count <= pair.count;
         idx_ff        <= 1'b0;
      end else if (drain_last) begin
         pair_ff.count <= 2'd0;
         idx_ff        <= 1'b0;
      end else if (fire) begin
         idx_ff <= 1'b1;
      end
      // payload needs no reset
      if (load) begin
         pair_ff.r0 <= pair.r0;
         pair_ff.r1 <= pair.r1;
      end
   end

   // second word is only selected on a two-word pair
   assert property (@(posedge clock) disable iff (reset)
      idx_ff |-> pair_ff.count == 2'd2)
      else $error("word index past pair count");

   // never load over words that are not yet taken
   assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("result register overwritten");

   // the final word of a pair carries last
   assert property (@(posedge clock) disable iff (reset)
      drain_last |-> rsp_word.last)
      else $error("last missing on final word");

endmodule

>>> sv/stuffed_frame_receiver_crc16_core.sv
// Top level of the byte-stuffed frame receiver with rotate-xor-add crc16.
// Depends on sfr_pkg, sfr_deframer and sfr_result_buf.
//
//   channel | direction | ports                                     | handshake
//   req     | in        | req_rx_byte                               | req_valid / req_ready
//   rsp     | out       | rsp_kind rsp_value rsp_status             | rsp_valid / rsp_ready
//           |           | rsp_data_count rsp_last                   |
//
// A line byte is registered on accept, decoded combinationally and its results land in
// the output register; one word per byte sustains one byte per clock while rsp_ready is high.
// An escape pair that yields two words holds back the next input byte until the
// single-word output port has sent both words.
// Synchronous reset returns to hunting with the crc at its seed.
// A stalled rsp_ready backs up into req_ready only once the output register is full.
module stuffed_frame_receiver_crc16_core
   import sfr_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEF,
   parameter int MAX_DATA  = MAX_DATA_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_value,
   output logic [1:0] rsp_status,
   output logic [6:0] rsp_data_count,
   output logic       rsp_last
);

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            step, load, free;
   result_pair_type pair;
   result_type      word;

   // a byte proceeds when its results have somewhere to go
   assign step      = in_valid_ff && (pair.count == 2'd0 || free);
   assign load      = step && pair.count != 2'd0;
   assign req_ready = !in_valid_ff || step;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   sfr_deframer #(
      .MAX_FRAME (MAX_FRAME),
      .MAX_DATA  (MAX_DATA)
   ) u_deframer (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .results (pair)
   );

   sfr_result_buf u_result_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .pair      (pair),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (word)
   );

   // result word onto the ports
   assign rsp_kind       = word.kind;
   assign rsp_value      = word.value;
   assign rsp_status     = word.status;
   assign rsp_data_count = word.data_count;
   assign rsp_last       = word.last;

endmodule
